[src/zuc_pkg.sv]
// ----------------------------------------------------------------------------
// ZUC-256 core package
// Shared types, S-box functions and round helpers for the keystream core.
// ----------------------------------------------------------------------------
package zuc_pkg;

    localparam logic [30:0] M31 = 31'h7FFFFFFF;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_KEY_A   = 3'd0;
    localparam logic [2:0] REG_KEY_B   = 3'd1;
    localparam logic [2:0] REG_KEY_C   = 3'd2;
    localparam logic [2:0] REG_KEY_D   = 3'd3;
    localparam logic [2:0] REG_IV_A    = 3'd4;
    localparam logic [2:0] REG_IV_B    = 3'd5;
    localparam logic [2:0] REG_IV_TAIL = 3'd6;
    localparam logic [2:0] REG_IV_MODE = 3'd7;

    typedef enum logic [0:0] {
        OP_RESTART = 1'b0,
        OP_CRYPT   = 1'b1
    } t_opcode;

    // One queued command between the front and the back end.
    typedef struct packed {
        logic        restart;
        logic        not_ready;
        logic        skip;
        logic [31:0] data;
        logic [31:0] mask;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_INIT = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    function automatic logic [7:0] sbox0(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
8'h3E,8'h72,8'h5B,8'h47,8'hCA,8'hE0,8'h00,8'h33,8'h04,8'hD1,8'h54,8'h98,8'h09,8'hB9,8'h6D,8'hCB,
8'h7B,8'h1B,8'hF9,8'h32,8'hAF,8'h9D,8'h6A,8'hA5,8'hB8,8'h2D,8'hFC,8'h1D,8'h08,8'h53,8'h03,8'h90,
8'h4D,8'h4E,8'h84,8'h99,8'hE4,8'hCE,8'hD9,8'h91,8'hDD,8'hB6,8'h85,8'h48,8'h8B,8'h29,8'h6E,8'hAC,
8'hCD,8'hC1,8'hF8,8'h1E,8'h73,8'h43,8'h69,8'hC6,8'hB5,8'hBD,8'hFD,8'h39,8'h63,8'h20,8'hD4,8'h38,
8'h76,8'h7D,8'hB2,8'hA7,8'hCF,8'hED,8'h57,8'hC5,8'hF3,8'h2C,8'hBB,8'h14,8'h21,8'h06,8'h55,8'h9B,
8'hE3,8'hEF,8'h5E,8'h31,8'h4F,8'h7F,8'h5A,8'hA4,8'h0D,8'h82,8'h51,8'h49,8'h5F,8'hBA,8'h58,8'h1C,
8'h4A,8'h16,8'hD5,8'h17,8'hA8,8'h92,8'h24,8'h1F,8'h8C,8'hFF,8'hD8,8'hAE,8'h2E,8'h01,8'hD3,8'hAD,
8'h3B,8'h4B,8'hDA,8'h46,8'hEB,8'hC9,8'hDE,8'h9A,8'h8F,8'h87,8'hD7,8'h3A,8'h80,8'h6F,8'h2F,8'hC8,
8'hB1,8'hB4,8'h37,8'hF7,8'h0A,8'h22,8'h13,8'h28,8'h7C,8'hCC,8'h3C,8'h89,8'hC7,8'hC3,8'h96,8'h56,
8'h07,8'hBF,8'h7E,8'hF0,8'h0B,8'h2B,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'hA6,8'h4C,8'h10,8'hFE,
8'hBC,8'h26,8'h95,8'h88,8'h8A,8'hB0,8'hA3,8'hFB,8'hC0,8'h18,8'h94,8'hF2,8'hE1,8'hE5,8'hE9,8'h5D,
8'hD0,8'hDC,8'h11,8'h66,8'h64,8'h5C,8'hEC,8'h59,8'h42,8'h75,8'h12,8'hF5,8'h74,8'h9C,8'hAA,8'h23,
8'h0E,8'h86,8'hAB,8'hBE,8'h2A,8'h02,8'hE7,8'h67,8'hE6,8'h44,8'hA2,8'h6C,8'hC2,8'h93,8'h9F,8'hF1,
8'hF6,8'hFA,8'h36,8'hD2,8'h50,8'h68,8'h9E,8'h62,8'h71,8'h15,8'h3D,8'hD6,8'h40,8'hC4,8'hE2,8'h0F,
8'h8E,8'h83,8'h77,8'h6B,8'h25,8'h05,8'h3F,8'h0C,8'h30,8'hEA,8'h70,8'hB7,8'hA1,8'hE8,8'hA9,8'h65,
8'h8D,8'h27,8'h1A,8'hDB,8'h81,8'hB3,8'hA0,8'hF4,8'h45,8'h7A,8'h19,8'hDF,8'hEE,8'h78,8'h34,8'h60};
        return tbl[x];
    endfunction

    function automatic logic [7:0] sbox1(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
8'h55,8'hC2,8'h63,8'h71,8'h3B,8'hC8,8'h47,8'h86,8'h9F,8'h3C,8'hDA,8'h5B,8'h29,8'hAA,8'hFD,8'h77,
8'h8C,8'hC5,8'h94,8'h0C,8'hA6,8'h1A,8'h13,8'h00,8'hE3,8'hA8,8'h16,8'h72,8'h40,8'hF9,8'hF8,8'h42,
8'h44,8'h26,8'h68,8'h96,8'h81,8'hD9,8'h45,8'h3E,8'h10,8'h76,8'hC6,8'hA7,8'h8B,8'h39,8'h43,8'hE1,
8'h3A,8'hB5,8'h56,8'h2A,8'hC0,8'h6D,8'hB3,8'h05,8'h22,8'h66,8'hBF,8'hDC,8'h0B,8'hFA,8'h62,8'h48,
8'hDD,8'h20,8'h11,8'h06,8'h36,8'hC9,8'hC1,8'hCF,8'hF6,8'h27,8'h52,8'hBB,8'h69,8'hF5,8'hD4,8'h87,
8'h7F,8'h84,8'h4C,8'hD2,8'h9C,8'h57,8'hA4,8'hBC,8'h4F,8'h9A,8'hDF,8'hFE,8'hD6,8'h8D,8'h7A,8'hEB,
8'h2B,8'h53,8'hD8,8'h5C,8'hA1,8'h14,8'h17,8'hFB,8'h23,8'hD5,8'h7D,8'h30,8'h67,8'h73,8'h08,8'h09,
8'hEE,8'hB7,8'h70,8'h3F,8'h61,8'hB2,8'h19,8'h8E,8'h4E,8'hE5,8'h4B,8'h93,8'h8F,8'h5D,8'hDB,8'hA9,
8'hAD,8'hF1,8'hAE,8'h2E,8'hCB,8'h0D,8'hFC,8'hF4,8'h2D,8'h46,8'h6E,8'h1D,8'h97,8'hE8,8'hD1,8'hE9,
8'h4D,8'h37,8'hA5,8'h75,8'h5E,8'h83,8'h9E,8'hAB,8'h82,8'h9D,8'hB9,8'h1C,8'hE0,8'hCD,8'h49,8'h89,
8'h01,8'hB6,8'hBD,8'h58,8'h24,8'hA2,8'h5F,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hB8,8'h95,8'hE4,
8'hD0,8'h91,8'hC7,8'hCE,8'hED,8'h0F,8'hB4,8'h6F,8'hA0,8'hCC,8'hF0,8'h02,8'h4A,8'h79,8'hC3,8'hDE,
8'hA3,8'hEF,8'hEA,8'h51,8'hE6,8'h6B,8'h18,8'hEC,8'h1B,8'h2C,8'h80,8'hF7,8'h74,8'hE7,8'hFF,8'h21,
8'h5A,8'h6A,8'h54,8'h1E,8'h41,8'h31,8'h92,8'h35,8'hC4,8'h33,8'h07,8'h0A,8'hBA,8'h7E,8'h0E,8'h34,
8'h88,8'hB1,8'h98,8'h7C,8'hF3,8'h3D,8'h60,8'h6C,8'h7B,8'hCA,8'hD3,8'h1F,8'h32,8'h65,8'h04,8'h28,
8'h64,8'hBE,8'h85,8'h9B,8'h2F,8'h59,8'h8A,8'hD7,8'hB0,8'h25,8'hAC,8'hAF,8'h12,8'h03,8'hE2,8'hF2};
        return tbl[x];
    endfunction

    function automatic logic [31:0] sbox_layer(input logic [31:0] x);
        return {sbox0(x[31:24]), sbox1(x[23:16]), sbox0(x[15:8]), sbox1(x[7:0])};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] lin1(input logic [31:0] x);
        return x ^ rotl(x, 2) ^ rotl(x, 10) ^ rotl(x, 18) ^ rotl(x, 24);
    endfunction

    function automatic logic [31:0] lin2(input logic [31:0] x);
        return x ^ rotl(x, 8) ^ rotl(x, 14) ^ rotl(x, 22) ^ rotl(x, 30);
    endfunction

    function automatic logic [30:0] madd(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] c;
        c = {1'b0, a} + {1'b0, b};
        return c[30:0] + {30'd0, c[31]};
    endfunction

    function automatic logic [30:0] mrot(input logic [30:0] a, input int n);
        return (a << n) | (a >> (31 - n));
    endfunction

    function automatic logic [30:0] mkcell(input logic [7:0] a, input logic [6:0] d,
                                           input logic [7:0] c, input logic [7:0] b);
        return {a, d, c, b};
    endfunction

endpackage

[src/zuc256_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// ZUC-256 stream cipher core
// Keystream engine with key/IV registers and a word-wide crypt stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tdata = {bytes_valid[34:32], data_word[31:0]}, tuser = opcode
//  m_axis    out        tdata = out_word[31:0], tuser = not_ready
//  cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data (no read-back)
//
// A crypt beat runs a single LFSR and FSM round that produces one keystream
// word, one per cycle while no held result stalls it; skipped and not-ready
// beats run no round. A restart loads the LFSR, runs INIT_ROUNDS + 1 rounds at
// one per cycle, and then places its zero result once the output is free.
// Reset is synchronous and active low. A two-entry command queue separates the
// input side from the round unit. A crypt beat waits while a result is held
// for m_axis_tready, but a restart can run its rounds in the meantime.
module zuc256_stream_cipher_core #(
    parameter int INIT_ROUNDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_word[31:0], bytes_valid[34:32]
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_word[31:0]
    output logic        m_axis_tuser,  // not_ready
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_cfg [7];
    logic        r_mode;
    logic [7:0]  w_k [32];
    logic [7:0]  w_iv [25];
    logic [30:0] w_load [16];
    logic        w_cmd_valid;
    logic        w_pop;
    zuc_pkg::t_cmd w_cmd;

    // Configuration registers; the IV tail keeps only its 56 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++) begin
                r_cfg[i] <= '0;
            end
            r_mode <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == zuc_pkg::REG_IV_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_idx == zuc_pkg::REG_IV_TAIL) begin
                r_cfg[zuc_pkg::REG_IV_TAIL] <= {8'd0, i_cfg_data[55:0]};
            end else begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    // Unpack key and IV bytes, then build the initial LFSR cells.
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            w_k[i] = r_cfg[zuc_pkg::REG_KEY_A + i/8][63-8*(i%8) -: 8];
        end
        for (int i = 0; i < 16; i++) begin
            w_iv[i] = r_cfg[zuc_pkg::REG_IV_A + i/8][63-8*(i%8) -: 8];
        end
        w_iv[16] = r_cfg[zuc_pkg::REG_IV_TAIL][55:48];
        for (int i = 0; i < 8; i++) begin
            w_iv[17+i] = {2'b00, r_cfg[zuc_pkg::REG_IV_TAIL][47-6*i -: 6]};
        end
        if (!r_mode) begin
            w_load[0]  = zuc_pkg::mkcell(w_k[0],  7'h64, w_k[16], w_k[24]);
            w_load[1]  = zuc_pkg::mkcell(w_k[1],  7'h43, w_k[17], w_k[25]);
            w_load[2]  = zuc_pkg::mkcell(w_k[2],  7'h7B, w_k[18], w_k[26]);
            w_load[3]  = zuc_pkg::mkcell(w_k[3],  7'h2A, w_k[19], w_k[27]);
            w_load[4]  = zuc_pkg::mkcell(w_k[4],  7'h11, w_k[20], w_k[28]);
            w_load[5]  = zuc_pkg::mkcell(w_k[5],  7'h05, w_k[21], w_k[29]);
            w_load[6]  = zuc_pkg::mkcell(w_k[6],  7'h51, w_k[22], w_k[30]);
            w_load[7]  = zuc_pkg::mkcell(w_k[7],  7'h42, w_iv[0], w_iv[8]);
            w_load[8]  = zuc_pkg::mkcell(w_k[8],  7'h1A, w_iv[1], w_iv[9]);
            w_load[9]  = zuc_pkg::mkcell(w_k[9],  7'h31, w_iv[2], w_iv[10]);
            w_load[10] = zuc_pkg::mkcell(w_k[10], 7'h18, w_iv[3], w_iv[11]);
            w_load[11] = zuc_pkg::mkcell(w_k[11], 7'h66, w_iv[4], w_iv[12]);
            w_load[12] = zuc_pkg::mkcell(w_k[12], 7'h14, w_iv[5], w_iv[13]);
            w_load[13] = zuc_pkg::mkcell(w_k[13], 7'h2E, w_iv[6], w_iv[14]);
            w_load[14] = zuc_pkg::mkcell(w_k[14], 7'h01, w_iv[7], w_iv[15]);
            w_load[15] = zuc_pkg::mkcell(w_k[15], 7'h5C, w_k[23], w_k[31]);
        end else begin
            w_load[0]  = zuc_pkg::mkcell(w_k[0], 7'h22, w_k[21], w_k[16]);
            w_load[1]  = zuc_pkg::mkcell(w_k[1], 7'h2F, w_k[22], w_k[17]);
            w_load[2]  = zuc_pkg::mkcell(w_k[2], 7'h24, w_k[23], w_k[18]);
            w_load[3]  = zuc_pkg::mkcell(w_k[3], 7'h2A, w_k[24], w_k[19]);
            w_load[4]  = zuc_pkg::mkcell(w_k[4], 7'h6D, w_k[25], w_k[20]);
            w_load[5]  = zuc_pkg::mkcell(w_iv[0], 7'h40 | w_iv[17][6:0], w_k[5], w_k[26]);
            w_load[6]  = zuc_pkg::mkcell(w_iv[1], 7'h40 | w_iv[18][6:0], w_k[6], w_k[27]);
            w_load[7]  = zuc_pkg::mkcell(w_iv[10], 7'h40 | w_iv[19][6:0], w_k[7], w_iv[2]);
            w_load[8]  = zuc_pkg::mkcell(w_k[8], 7'h40 | w_iv[20][6:0], w_iv[3], w_iv[11]);
            w_load[9]  = zuc_pkg::mkcell(w_k[9], 7'h40 | w_iv[21][6:0], w_iv[12], w_iv[4]);
            w_load[10] = zuc_pkg::mkcell(w_iv[5], 7'h40 | w_iv[22][6:0], w_k[10], w_k[28]);
            w_load[11] = zuc_pkg::mkcell(w_k[11], 7'h40 | w_iv[23][6:0], w_iv[6], w_iv[13]);
            w_load[12] = zuc_pkg::mkcell(w_k[12], 7'h40 | w_iv[24][6:0], w_iv[7], w_iv[14]);
            w_load[13] = zuc_pkg::mkcell(w_k[13], 7'h52, w_iv[15], w_iv[8]);
            w_load[14] = zuc_pkg::mkcell(w_k[14], 7'h10 | {3'd0, w_k[31][7:4]}, w_iv[16], w_iv[9]);
            w_load[15] = zuc_pkg::mkcell(w_k[15], 7'h30 | {3'd0, w_k[31][3:0]}, w_k[30], w_k[29]);
        end
    end

    zuc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data      (s_axis_tdata[31:0]),
        .i_nb        (s_axis_tdata[34:32]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_pop),
        .o_cmd       (w_cmd)
    );

    zuc_back #(
        .INIT_ROUNDS (INIT_ROUNDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_pop),
        .i_cmd       (w_cmd),
        .i_load      (w_load),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_word      (m_axis_tdata),
        .o_not_ready (m_axis_tuser)
    );

endmodule

[src/zuc_front.sv]
// ----------------------------------------------------------------------------
// ZUC-256 front end
// Accepts beats, classifies them and pushes commands into a two-entry queue.
// ----------------------------------------------------------------------------
module zuc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [31:0]       i_data,
    input  logic [2:0]        i_nb,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output zuc_pkg::t_cmd     o_cmd
);

    zuc_pkg::t_cmd r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;
    logic          r_init;
    zuc_pkg::t_cmd w_cmd;
    logic          w_push;
    logic [2:0]    w_nb;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        w_nb = (i_nb > 3'd4) ? 3'd4 : i_nb;
        w_cmd.restart   = (i_opcode == zuc_pkg::OP_RESTART);
        w_cmd.not_ready = (i_opcode == zuc_pkg::OP_CRYPT) && !r_init;
        w_cmd.skip      = (i_opcode == zuc_pkg::OP_CRYPT) && (w_nb == 3'd0);
        w_cmd.data      = i_data;
        case (w_nb)
            3'd1:    w_cmd.mask = 32'hFF000000;
            3'd2:    w_cmd.mask = 32'hFFFF0000;
            3'd3:    w_cmd.mask = 32'hFFFFFF00;
            3'd4:    w_cmd.mask = 32'hFFFFFFFF;
            default: w_cmd.mask = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
            r_cnt  <= 2'd0;
            r_init <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
                if (w_cmd.restart) begin
                    r_init <= 1'b1;
                end
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

[src/zuc_back.sv]
// ----------------------------------------------------------------------------
// ZUC-256 back end
// Runs the LFSR and FSM rounds, one round per cycle unless a held result stalls a crypt beat, and drives the result.
// ----------------------------------------------------------------------------
module zuc_back #(
    parameter int INIT_ROUNDS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  zuc_pkg::t_cmd     i_cmd,
    input  logic [30:0]       i_load [16],
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_word,
    output logic              o_not_ready
);

    localparam int CW = $clog2(INIT_ROUNDS + 2);

    zuc_pkg::t_state r_state, n_state;
    logic [30:0]     r_s [16];
    logic [31:0]     r_r1, r_r2;
    logic [CW-1:0]   r_cnt;
    logic            r_ov;
    logic [31:0]     r_word;
    logic            r_nr;

    logic [31:0] w_x0, w_x1, w_x2, w_x3, w_w, w_w1, w_w2, w_r1, w_r2;
    logic [30:0] w_v;
    logic        w_initmode;
    logic        w_out_free;
    logic        w_take;
    logic        w_round;
    logic        w_crypt;

    assign w_out_free = !r_ov || i_ready;
    assign o_valid    = r_ov;
    assign o_word     = r_word;
    assign o_not_ready = r_nr;

    // Round datapath.
    always_comb begin
        w_x0 = {r_s[15][30:15], r_s[14][15:0]};
        w_x1 = {r_s[11][15:0], r_s[9][30:15]};
        w_x2 = {r_s[7][15:0], r_s[5][30:15]};
        w_x3 = {r_s[2][15:0], r_s[0][30:15]};
        w_w  = (w_x0 ^ r_r1) + r_r2;
        w_w1 = r_r1 + w_x1;
        w_w2 = r_r2 ^ w_x2;
        w_r1 = zuc_pkg::sbox_layer(zuc_pkg::lin1({w_w1[15:0], w_w2[31:16]}));
        w_r2 = zuc_pkg::sbox_layer(zuc_pkg::lin2({w_w2[15:0], w_w1[31:16]}));
        w_initmode = (r_state == zuc_pkg::ST_INIT) && (r_cnt < CW'(INIT_ROUNDS));
        w_v = zuc_pkg::madd(r_s[0], zuc_pkg::mrot(r_s[0], 8));
        w_v = zuc_pkg::madd(w_v, zuc_pkg::mrot(r_s[4], 20));
        w_v = zuc_pkg::madd(w_v, zuc_pkg::mrot(r_s[10], 21));
        w_v = zuc_pkg::madd(w_v, zuc_pkg::mrot(r_s[13], 17));
        w_v = zuc_pkg::madd(w_v, zuc_pkg::mrot(r_s[15], 15));
        if (w_initmode) begin
            w_v = zuc_pkg::madd(w_v, w_w[31:1]);
        end
        if (w_v == 31'd0) begin
            w_v = zuc_pkg::M31;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            zuc_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.restart) begin
                    n_state = zuc_pkg::ST_INIT;
                end
            end
            zuc_pkg::ST_INIT: begin
                if (r_cnt == CW'(INIT_ROUNDS)) begin
                    n_state = zuc_pkg::ST_OUT;
                end
            end
            zuc_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = zuc_pkg::ST_IDLE;
                end
            end
            default: n_state = zuc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        w_take  = 1'b0;
        w_round = 1'b0;
        w_crypt = 1'b0;
        case (r_state)
            zuc_pkg::ST_IDLE: begin
                w_take  = i_cmd_valid && (i_cmd.restart || w_out_free);
                w_crypt = i_cmd_valid && !i_cmd.restart && w_out_free;
                w_round = w_crypt && !i_cmd.not_ready && !i_cmd.skip;
            end
            zuc_pkg::ST_INIT: w_round = 1'b1;
            default: ;
        endcase
    end

    assign o_cmd_pop = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zuc_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == zuc_pkg::ST_INIT) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_crypt || ((r_state == zuc_pkg::ST_OUT) && w_out_free)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_s[i] <= '0;
            end
            r_r1 <= '0;
            r_r2 <= '0;
        end else if (w_take && i_cmd.restart) begin
            r_s  <= i_load;
            r_r1 <= '0;
            r_r2 <= '0;
        end else if (w_round) begin
            for (int i = 0; i < 15; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[15] <= w_v;
            r_r1 <= w_r1;
            r_r2 <= w_r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_crypt) begin
            r_nr   <= i_cmd.not_ready;
            r_word <= (i_cmd.not_ready || i_cmd.skip) ? 32'd0
                    : ((i_cmd.data ^ w_w ^ w_x3) & i_cmd.mask);
        end else if ((r_state == zuc_pkg::ST_OUT) && w_out_free) begin
            r_nr   <= 1'b0;
            r_word <= 32'd0;
        end
    end

endmodule
